/* hw/rtl/zmd_pkg.sv */
// Shared types, register indexes, command codes and reset values of the zone motion detector.
package zmd_pkg;

  // Default sizes of the block.
  localparam int unsigned MAX_FRAME_PIXELS_DEF = 524288;
  localparam int unsigned NUM_ZONES_DEF        = 5;
  localparam int unsigned HISTORY_DEPTH_DEF    = 3;

  // Register reset values.
  localparam logic [7:0]  DIFF_THRESHOLD_RST = 8'd30;
  localparam logic [10:0] FRAME_WIDTH_RST    = 11'd640;
  localparam logic [9:0]  FRAME_HEIGHT_RST   = 10'd480;
  localparam logic [10:0] ZONE_WIDTH_RST     = 11'd128;
  localparam logic [19:0] FULL_SCALE_RST     = 20'd10000;
  localparam logic [19:0] TRIGGER_LEVEL_RST  = 20'd4000;
  localparam logic [15:0] RUN_LENGTH_RST     = 16'd2100;
  localparam logic [7:0]  ARM_TICKS_RST      = 8'd90;

  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W  = 3;

  // Register indexes on the write port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIFF_THRESHOLD = 3'd0,
    REG_FRAME_WIDTH    = 3'd1,
    REG_FRAME_HEIGHT   = 3'd2,
    REG_ZONE_WIDTH     = 3'd3,
    REG_FULL_SCALE     = 3'd4,
    REG_TRIGGER_LEVEL  = 3'd5,
    REG_RUN_LENGTH     = 3'd6,
    REG_ARM_TICKS      = 3'd7
  } reg_idx_e;

  // Input word kinds.
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] gray;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [2:0]  zone_index;
    logic [19:0] raw_count;
    logic [19:0] smoothed_count;
    logic [15:0] level;
    logic        tracks_on;
    logic        tracks_off;
    logic        last_zone;
  } out_t;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_TICK,
    CMD_PIXEL,
    CMD_LOOK,
    CMD_SEARCH,
    CMD_UPDATE,
    CMD_ZONE_CALC,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_NEXT_ZONE
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic search_done;
    logic frame_end;
    logic div_last;
    logic last_zone;
  } sts_t;

endpackage

/* hw/rtl/zmd_datapath.sv */
// Datapath of the zone motion detector: frame store, position, zone counts, smoothing and level.
module zmd_datapath #(
  parameter int unsigned MAX_FRAME_PIXELS = zmd_pkg::MAX_FRAME_PIXELS_DEF,
  parameter int unsigned NUM_ZONES        = zmd_pkg::NUM_ZONES_DEF,
  parameter int unsigned HISTORY_DEPTH    = zmd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  zmd_pkg::in_t                        in_data_i,
  input  logic                                cfg_we_i,
  input  logic [zmd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [zmd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  zmd_pkg::cmd_t                       cmd_i,
  output zmd_pkg::sts_t                       sts_o,
  output zmd_pkg::out_t                       out_data_o
);

  localparam int unsigned AW    = (MAX_FRAME_PIXELS > 1) ? $clog2(MAX_FRAME_PIXELS) : 1;
  localparam int unsigned ZW    = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
  localparam int unsigned Div   = HISTORY_DEPTH + 1;
  localparam int unsigned Sh    = 25;
  localparam logic [24:0] Recip = 25'(((64'd1 << Sh) + Div - 1) / Div);
  localparam logic [19:0] MaxIdx  = 20'(MAX_FRAME_PIXELS);
  localparam logic [AW-1:0] ClrLast = AW'(MAX_FRAME_PIXELS - 1);

  // Configuration registers.
  logic [7:0]  thr_q;
  logic [10:0] fw_q;
  logic [9:0]  fh_q;
  logic [10:0] zw_q;
  logic [19:0] fs_q;
  logic [19:0] trig_q;
  logic [15:0] rlen_q;
  logic [7:0]  arm_q;

  // Pixel path state.
  logic [9:0]  col_q;
  logic [8:0]  line_q;
  logic [7:0]  gray_q;
  logic [19:0] idx_q;
  logic [3:0]  zone_q;
  logic [14:0] bound_q;
  logic [7:0]  rd_q;
  logic [AW-1:0] clr_q;
  logic [19:0] cnt_q [NUM_ZONES];
  logic [19:0] hist_q [NUM_ZONES][HISTORY_DEPTH];

  // Trigger state.
  logic [15:0] run_cnt_q;
  logic        run_inc_q;
  logic        on_q;
  logic        off_q;
  logic [7:0]  up_q;

  // Result path state.
  logic [2:0]  ez_q;
  logic [19:0] raw_q;
  logic [19:0] mean_q;
  logic [19:0] rem_q;
  logic [15:0] nlow_q;
  logic [15:0] quo_q;
  logic [3:0]  dcnt_q;

  // Frame store.
  logic [7:0] mem [MAX_FRAME_PIXELS];

  logic [10:0] w_eff;
  logic [9:0]  h_eff;
  logic [10:0] zw_eff;
  logic [19:0] fs_eff;
  logic        idx_ok;
  logic [7:0]  diff;
  logic        zone_in;
  logic [ZW-1:0] csel;
  logic [19:0] cnt_rd;
  logic [21:0] sum;
  logic [46:0] prod;
  logic [19:0] mean_w;
  logic [19:0] clip;
  logic [35:0] numer;
  logic [20:0] trial;
  logic        trial_ge;
  logic        trig_hit;
  logic        line_end;
  logic        frame_end;
  logic        mem_we;
  logic [AW-1:0] mem_addr;
  logic [19:0] idx_w;

  // Clamped geometry and scale.
  assign w_eff  = (fw_q == 11'd0) ? 11'd1 : ((fw_q > 11'd1024) ? 11'd1024 : fw_q);
  assign h_eff  = (fh_q == 10'd0) ? 10'd1 : ((fh_q > 10'd512) ? 10'd512 : fh_q);
  assign zw_eff = (zw_q == 11'd0) ? 11'd1 : zw_q;
  assign fs_eff = (fs_q == 20'd0) ? 20'd1 : fs_q;

  // Pixel compare and position.
  assign idx_w     = 20'(line_q) * 20'(w_eff) + 20'(col_q);
  assign idx_ok    = idx_q < MaxIdx;
  assign diff      = (gray_q > rd_q) ? (gray_q - rd_q) : (rd_q - gray_q);
  assign zone_in   = zone_q < 4'(NUM_ZONES);
  assign line_end  = (11'(col_q) + 11'd1) >= w_eff;
  assign frame_end = line_end && ((10'(line_q) + 10'd1) >= h_eff);

  // One zone count read port, shared by the pixel and result paths.
  assign csel   = (cmd_i.op == zmd_pkg::CMD_ZONE_CALC) ? ez_q[ZW-1:0] : zone_q[ZW-1:0];
  assign cnt_rd = cnt_q[csel];

  // Mean of the current count and its history by a reciprocal multiply.
  always_comb begin
    sum = 22'(cnt_rd);
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      sum = sum + 22'(hist_q[ez_q[ZW-1:0]][k]);
    end
  end
  assign prod   = 47'(sum) * 47'(Recip);
  assign mean_w = prod[Sh+19:Sh];

  // Level divider: one restoring step per cycle.
  assign clip     = (mean_q < fs_eff) ? mean_q : fs_eff;
  assign numer    = {clip, 16'd0} - {16'd0, clip};
  assign trial    = {rem_q, nlow_q[15]};
  assign trial_ge = trial >= {1'b0, fs_eff};

  assign trig_hit = (cnt_rd >= trig_q) && (up_q >= arm_q);

  // Status toward the controller.
  assign sts_o.clear_done  = clr_q == ClrLast;
  assign sts_o.search_done = !(zone_in && (15'(col_q) >= bound_q));
  assign sts_o.frame_end   = frame_end;
  assign sts_o.div_last    = dcnt_q == 4'd15;
  assign sts_o.last_zone   = ez_q == 3'(NUM_ZONES - 1);

  // Result word.
  assign out_data_o.zone_index     = ez_q;
  assign out_data_o.raw_count      = raw_q;
  assign out_data_o.smoothed_count = mean_q;
  assign out_data_o.level          = quo_q;
  assign out_data_o.tracks_on      = on_q;
  assign out_data_o.tracks_off     = off_q;
  assign out_data_o.last_zone      = ez_q == 3'(NUM_ZONES - 1);

  // Frame store port: clearing pass or pixel write back.
  assign mem_we   = (cmd_i.op == zmd_pkg::CMD_CLEAR) ||
                    ((cmd_i.op == zmd_pkg::CMD_UPDATE) && idx_ok);
  assign mem_addr = (cmd_i.op == zmd_pkg::CMD_CLEAR) ? clr_q : idx_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= (cmd_i.op == zmd_pkg::CMD_CLEAR) ? 8'd0 : gray_q;
    end
    rd_q <= mem[mem_addr];
  end

  // Payload registers of the pixel and result paths.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      zmd_pkg::CMD_PIXEL: begin
        gray_q <= in_data_i.gray;
      end
      zmd_pkg::CMD_LOOK: begin
        idx_q   <= idx_w;
        zone_q  <= 4'd0;
        bound_q <= 15'(zw_eff);
      end
      zmd_pkg::CMD_SEARCH: begin
        if (zone_in && (15'(col_q) >= bound_q)) begin
          zone_q  <= zone_q + 4'd1;
          bound_q <= bound_q + 15'(zw_eff);
        end
      end
      zmd_pkg::CMD_ZONE_CALC: begin
        raw_q  <= cnt_rd;
        mean_q <= mean_w;
      end
      zmd_pkg::CMD_DIV_INIT: begin
        rem_q  <= numer[35:16];
        nlow_q <= numer[15:0];
        quo_q  <= 16'd0;
      end
      zmd_pkg::CMD_DIV_STEP: begin
        rem_q  <= trial_ge ? 20'(trial - {1'b0, fs_eff}) : trial[19:0];
        nlow_q <= {nlow_q[14:0], 1'b0};
        quo_q  <= {quo_q[14:0], trial_ge};
      end
      default: begin
      end
    endcase
  end

  // Control state: registers, position, counts, history and trigger.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= zmd_pkg::DIFF_THRESHOLD_RST;
      fw_q      <= zmd_pkg::FRAME_WIDTH_RST;
      fh_q      <= zmd_pkg::FRAME_HEIGHT_RST;
      zw_q      <= zmd_pkg::ZONE_WIDTH_RST;
      fs_q      <= zmd_pkg::FULL_SCALE_RST;
      trig_q    <= zmd_pkg::TRIGGER_LEVEL_RST;
      rlen_q    <= zmd_pkg::RUN_LENGTH_RST;
      arm_q     <= zmd_pkg::ARM_TICKS_RST;
      col_q     <= '0;
      line_q    <= '0;
      clr_q     <= '0;
      run_cnt_q <= '0;
      run_inc_q <= 1'b0;
      on_q      <= 1'b0;
      off_q     <= 1'b0;
      up_q      <= '0;
      ez_q      <= '0;
      dcnt_q    <= '0;
      for (int z = 0; z < NUM_ZONES; z++) begin
        cnt_q[z] <= '0;
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
          hist_q[z][k] <= '0;
        end
      end
    end else begin
      // Register writes.
      if (cfg_we_i) begin
        case (cfg_index_i)
          zmd_pkg::REG_DIFF_THRESHOLD: thr_q  <= cfg_data_i[7:0];
          zmd_pkg::REG_FRAME_WIDTH:    fw_q   <= cfg_data_i[10:0];
          zmd_pkg::REG_FRAME_HEIGHT:   fh_q   <= cfg_data_i[9:0];
          zmd_pkg::REG_ZONE_WIDTH:     zw_q   <= cfg_data_i[10:0];
          zmd_pkg::REG_FULL_SCALE:     fs_q   <= cfg_data_i[19:0];
          zmd_pkg::REG_TRIGGER_LEVEL:  trig_q <= cfg_data_i[19:0];
          zmd_pkg::REG_RUN_LENGTH:     rlen_q <= cfg_data_i[15:0];
          zmd_pkg::REG_ARM_TICKS:      arm_q  <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end

      case (cmd_i.op)
        zmd_pkg::CMD_CLEAR: begin
          clr_q <= clr_q + AW'(1);
        end
        zmd_pkg::CMD_TICK: begin
          if (run_inc_q && (run_cnt_q != 16'hFFFF)) begin
            run_cnt_q <= run_cnt_q + 16'd1;
          end
          if ((up_q < arm_q) && (up_q != 8'hFF)) begin
            up_q <= up_q + 8'd1;
          end
        end
        zmd_pkg::CMD_PIXEL: begin
          // A frame start drops the counts of an unfinished frame.
          if (in_data_i.frame_start) begin
            col_q  <= '0;
            line_q <= '0;
            for (int z = 0; z < NUM_ZONES; z++) begin
              cnt_q[z] <= '0;
            end
          end
        end
        zmd_pkg::CMD_UPDATE: begin
          if (idx_ok && (diff > thr_q) && zone_in && (cnt_rd != 20'hFFFFF)) begin
            cnt_q[csel] <= cnt_rd + 20'd1;
          end
          if (line_end) begin
            col_q <= '0;
            if (frame_end) begin
              line_q <= '0;
              ez_q   <= '0;
            end else begin
              line_q <= line_q + 9'd1;
            end
          end else begin
            col_q <= col_q + 10'd1;
          end
        end
        zmd_pkg::CMD_ZONE_CALC: begin
          for (int k = 0; k + 1 < HISTORY_DEPTH; k++) begin
            hist_q[ez_q[ZW-1:0]][k] <= hist_q[ez_q[ZW-1:0]][k+1];
          end
          hist_q[ez_q[ZW-1:0]][HISTORY_DEPTH-1] <= cnt_rd;
          cnt_q[csel] <= '0;
          if (trig_hit) begin
            on_q      <= 1'b1;
            off_q     <= 1'b0;
            run_inc_q <= 1'b1;
          end else if (run_cnt_q >= rlen_q) begin
            on_q      <= 1'b0;
            off_q     <= 1'b1;
            run_inc_q <= 1'b0;
            run_cnt_q <= '0;
          end
        end
        zmd_pkg::CMD_DIV_INIT: begin
          dcnt_q <= '0;
        end
        zmd_pkg::CMD_DIV_STEP: begin
          dcnt_q <= dcnt_q + 4'd1;
        end
        zmd_pkg::CMD_NEXT_ZONE: begin
          ez_q <= ez_q + 3'd1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* hw/rtl/zmd_ctrl.sv */
// Controller state machine of the zone motion detector.
module zmd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_req_type_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  zmd_pkg::sts_t sts_i,
  output zmd_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_SEARCH,
    S_UPDATE,
    S_EMIT,
    S_DINIT,
    S_DIV,
    S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  // Command for the current state.
  always_comb begin
    cmd_o.op = zmd_pkg::CMD_NONE;
    case (state_q)
      S_CLEAR:  cmd_o.op = zmd_pkg::CMD_CLEAR;
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = (in_req_type_i == zmd_pkg::REQ_TICK) ? zmd_pkg::CMD_TICK
                                                           : zmd_pkg::CMD_PIXEL;
        end
      end
      S_LOOK:   cmd_o.op = zmd_pkg::CMD_LOOK;
      S_SEARCH: cmd_o.op = zmd_pkg::CMD_SEARCH;
      S_UPDATE: cmd_o.op = zmd_pkg::CMD_UPDATE;
      S_EMIT:   cmd_o.op = zmd_pkg::CMD_ZONE_CALC;
      S_DINIT:  cmd_o.op = zmd_pkg::CMD_DIV_INIT;
      S_DIV:    cmd_o.op = zmd_pkg::CMD_DIV_STEP;
      S_OUT: begin
        if (out_ready_i) begin
          cmd_o.op = zmd_pkg::CMD_NEXT_ZONE;
        end
      end
      default:  cmd_o.op = zmd_pkg::CMD_NONE;
    endcase
  end

  // State and the registered result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (sts_i.clear_done) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i && (in_req_type_i == zmd_pkg::REQ_PIXEL)) begin
            state_q <= S_LOOK;
          end
        end
        S_LOOK:   state_q <= S_SEARCH;
        S_SEARCH: begin
          if (sts_i.search_done) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: state_q <= sts_i.frame_end ? S_EMIT : S_IDLE;
        S_EMIT:   state_q <= S_DINIT;
        S_DINIT:  state_q <= S_DIV;
        S_DIV: begin
          if (sts_i.div_last) begin
            state_q     <= S_OUT;
            out_valid_q <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= sts_i.last_zone ? S_IDLE : S_EMIT;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/zone_motion_detector.sv */
// Top level of the zone motion detector.
// Frame-difference motion detector over vertical zones. After reset the
// frame store is cleared, one pixel a cycle; no word is taken during that
// pass, but register writes are. A tick word is handled without leaving
// the idle state. A pixel word runs through the look, search and update
// states: the zone search steps one zone boundary per cycle, and the single
// frame store port is read before the pixel is written back. The last pixel
// of a frame is followed by one result word per zone, each built from the
// count and history mean, a set-up of the level divider and a division of
// one quotient bit per step into the 16-bit level, held until out_ready_i.
module zone_motion_detector #(
  parameter int unsigned MAX_FRAME_PIXELS = zmd_pkg::MAX_FRAME_PIXELS_DEF,
  parameter int unsigned NUM_ZONES        = zmd_pkg::NUM_ZONES_DEF,
  parameter int unsigned HISTORY_DEPTH    = zmd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  zmd_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output zmd_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [zmd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [zmd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  zmd_pkg::cmd_t cmd;
  zmd_pkg::sts_t sts;

  zmd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_req_type_i (in_data_i.req_type),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  zmd_datapath #(
    .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS),
    .NUM_ZONES        (NUM_ZONES),
    .HISTORY_DEPTH    (HISTORY_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

/* hw/rtl/zmd_checker.sv */
// Port checker of the zone motion detector and its bind to the top level.
module zmd_checker #(
  parameter int unsigned NUM_ZONES = zmd_pkg::NUM_ZONES_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input zmd_pkg::out_t out_data_o
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // The last-zone mark sits on the highest zone only.
  a_last_zone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_zone == (out_data_o.zone_index == 3'(NUM_ZONES - 1))))
    else $error("last zone mark on wrong zone");

  // No new word is taken while a result waits.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input ready while a result is pending");

  // The run flags never both stand.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.tracks_on && out_data_o.tracks_off))
    else $error("run on and off flags both set");

  // No motion in the mean gives a zero level.
  a_zero_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.smoothed_count == 20'd0) |-> out_data_o.level == 16'd0)
    else $error("nonzero level for zero mean");

endmodule

bind zone_motion_detector zmd_checker #(.NUM_ZONES(NUM_ZONES)) u_zmd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
